>>> rtl/ngc_pkg.sv
// Shared types and constants for the network group classifier.
`default_nettype none
package ngc_pkg;

  localparam int unsigned MaxBytes   = 11;
  localparam int unsigned LenW       = 4;
  localparam int unsigned QueueDepth = 2;

  // group class codes
  localparam logic [7:0] ClsUnroutable = 8'd0;
  localparam logic [7:0] ClsIpv4       = 8'd1;
  localparam logic [7:0] ClsIpv6       = 8'd2;
  localparam logic [7:0] ClsOnion      = 8'd3;
  localparam logic [7:0] ClsInternal   = 8'd4;

  localparam logic [47:0] OnionPfx  = 48'hFD87_D87E_EB43;
  localparam logic [47:0] InternPfx = 48'hFD6B_88C0_8724;
  localparam logic [95:0] Nat64Pfx  = 96'h0064_FF9B_0000_0000_0000_0000;
  localparam logic [95:0] SiitPfx   = 96'h0000_0000_0000_0000_FFFF_0000;
  localparam logic [63:0] LlocalPfx = 64'hFE80_0000_0000_0000;
  localparam logic [15:0] Pfx2001   = 16'h2001;
  localparam logic [15:0] Pfx6to4   = 16'h2002;
  localparam logic [31:0] TeredoPfx = 32'h2001_0000;
  localparam logic [31:0] ProvPfx   = 32'h2001_0470;
  localparam logic [7:0]  UlaMask   = 8'hFE;
  localparam logic [7:0]  UlaVal    = 8'hFC;
  localparam logic [7:0]  LowNibble = 8'h0F;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        is_v4;
  } in_item_t;

  typedef struct packed {
    logic [7:0] group_byte;
    logic       last;
  } out_item_t;

  // one classified address: bytes to emit, first byte in entry 0
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] grp_bytes;
    logic [LenW-1:0]          len;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/ngc_front.sv
// Front end: input register and address classification into a group entry.
`default_nettype none
module ngc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire ngc_pkg::in_item_t  item_i,
  input  wire ngc_pkg::q_status_t status_i,
  output logic                    push_o,
  output ngc_pkg::group_t         group_o
);

  logic              f_valid_q, f_valid_d;
  ngc_pkg::in_item_t f_item_q;
  logic              accept;

  logic [127:0] av;
  logic [7:0]   p, q, r;
  logic v4, onion, internal, v6, loopback, local_addr;
  logic priv, bench, v4link, cgnat, doc4, p2001, v6link, ula, orchid, orchid2;
  logic sixto4, nat64, teredo, siit, routable;

  assign busy_o  = f_valid_q && status_i.full;
  assign accept  = start_i && !busy_o;
  assign push_o  = f_valid_q && !status_i.full;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= item_i;
    end
  end

  // IPv4 goes to the mapped form ::ffff:a.b.c.d
  always_comb begin
    v4 = f_item_q.is_v4;
    av = v4 ? {80'h0, 16'hFFFF, f_item_q.addr_low[31:0]}
            : {f_item_q.addr_high, f_item_q.addr_low};
    p  = av[31:24];
    q  = av[23:16];
    r  = av[15:8];

    onion      = !v4 && (av[127:80] == ngc_pkg::OnionPfx);
    internal   = !v4 && !onion && (av[127:80] == ngc_pkg::InternPfx);
    v6         = !v4 && !onion && !internal;
    loopback   = v4 ? (p == 8'd127) : (av == 128'h1);
    local_addr = loopback || (v4 && (p == 8'd0));

    priv   = v4 && ((p == 8'd10) || ((p == 8'd192) && (q == 8'd168)) ||
                    ((p == 8'd172) && (q[7:4] == 4'h1)));
    bench  = v4 && (p == 8'd198) && (q[7:1] == 7'd9);
    v4link = v4 && (p == 8'd169) && (q == 8'd254);
    cgnat  = v4 && (p == 8'd100) && (q[7:6] == 2'b01);
    doc4   = v4 && (((p == 8'd192) && (q == 8'd0) && (r == 8'd2)) ||
                    ((p == 8'd198) && (q == 8'd51) && (r == 8'd100)) ||
                    ((p == 8'd203) && (q == 8'd0) && (r == 8'd113)));
    p2001   = v6 && (av[127:112] == ngc_pkg::Pfx2001);
    v6link  = v6 && (av[127:64] == ngc_pkg::LlocalPfx);
    ula     = v6 && ((av[127:120] & ngc_pkg::UlaMask) == ngc_pkg::UlaVal);
    orchid  = p2001 && (av[111:104] == 8'd0) && (av[103:100] == 4'h1);
    orchid2 = p2001 && (av[111:104] == 8'd0) && (av[103:100] == 4'h2);
    sixto4  = v6 && (av[127:112] == ngc_pkg::Pfx6to4);
    nat64   = v6 && (av[127:32] == ngc_pkg::Nat64Pfx);
    teredo  = v6 && (av[127:96] == ngc_pkg::TeredoPfx);
    siit    = v6 && (av[127:32] == ngc_pkg::SiitPfx);
    routable = !(priv || bench || v4link || v6link || cgnat || doc4 || ula ||
                 orchid || orchid2 || local_addr || internal);

    group_o = '0;
    if (internal) begin
      group_o.len          = ngc_pkg::LenW'(ngc_pkg::MaxBytes);
      group_o.grp_bytes[0] = ngc_pkg::ClsInternal;
      for (int k = 0; k < 10; k++) begin
        group_o.grp_bytes[k+1] = av[79-8*k -: 8];
      end
    end else if (!routable) begin
      group_o.len          = ngc_pkg::LenW'(1);
      group_o.grp_bytes[0] = ngc_pkg::ClsUnroutable;
    end else if (v4 || siit || nat64 || sixto4 || teredo) begin
      group_o.len          = ngc_pkg::LenW'(3);
      group_o.grp_bytes[0] = ngc_pkg::ClsIpv4;
      if (v4 || siit || nat64) begin
        group_o.grp_bytes[1] = av[31:24];
        group_o.grp_bytes[2] = av[23:16];
      end else if (sixto4) begin
        group_o.grp_bytes[1] = av[111:104];
        group_o.grp_bytes[2] = av[103:96];
      end else begin
        group_o.grp_bytes[1] = ~av[31:24];
        group_o.grp_bytes[2] = ~av[23:16];
      end
    end else if (onion) begin
      group_o.len          = ngc_pkg::LenW'(2);
      group_o.grp_bytes[0] = ngc_pkg::ClsOnion;
      group_o.grp_bytes[1] = av[79:72] | ngc_pkg::LowNibble;
    end else begin
      group_o.grp_bytes[0] = ngc_pkg::ClsIpv6;
      group_o.grp_bytes[1] = av[127:120];
      group_o.grp_bytes[2] = av[119:112];
      group_o.grp_bytes[3] = av[111:104];
      group_o.grp_bytes[4] = av[103:96];
      if (av[127:96] == ngc_pkg::ProvPfx) begin
        group_o.len          = ngc_pkg::LenW'(6);
        group_o.grp_bytes[5] = av[95:88] | ngc_pkg::LowNibble;
      end else begin
        group_o.len = ngc_pkg::LenW'(5);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ngc_queue.sv
// Short queue of classified group entries between front and back end.
`default_nettype none
module ngc_queue #(
  parameter int unsigned Depth = ngc_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ngc_pkg::group_t  data_i,
  input  wire logic             pop_i,
  output ngc_pkg::group_t       head_o,
  output ngc_pkg::q_status_t    status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ngc_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ngc_back.sv
// Back end: walks the queue head entry and emits one group byte per cycle while the queue is not empty.
`default_nettype none
module ngc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ngc_pkg::group_t    head_i,
  input  wire ngc_pkg::q_status_t status_i,
  output logic                    pop_o,
  output logic                    valid_o,
  output ngc_pkg::out_item_t      result_o
);

  logic [ngc_pkg::LenW-1:0] idx_q, idx_d;
  logic                     valid_q;
  ngc_pkg::out_item_t       result_q;
  logic [7:0]               sel_byte;
  logic                     is_last;

  always_comb begin
    sel_byte = head_i.grp_bytes[idx_q];
    is_last  = (idx_q == head_i.len - ngc_pkg::LenW'(1));
    pop_o    = !status_i.empty && is_last;
    idx_d    = idx_q;
    if (!status_i.empty) begin
      idx_d = is_last ? '0 : idx_q + ngc_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= !status_i.empty;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.group_byte <= sel_byte;
    result_q.last       <= is_last;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

>>> rtl/network_group_classifier_unit.sv
// Top level of the peer address network group classifier.
//
// Input: an item (addr_high, addr_low, is_v4) is taken at a rising edge where
// start_i is high and busy_o is low. Output: each group byte appears on
// result_o for exactly one cycle with valid_o high; result_o.last marks the
// final byte of an address. The first byte is the class code, followed by
// zero to ten group bytes, so one address gives 1 to 11 results.
// Path: the first byte of an item passes through the classify register, a
// queue entry and the output register. Throughput: the byte emitter puts out
// one byte per cycle while the queue holds an entry, so the sustained input
// rate is bounded by the bytes per address, up to 11 for internal addresses. The entry queue
// (QueueDepth entries) plus the classify register absorb bursts; busy_o rises
// only while that register holds an item and the queue is full.
// The receiver cannot stall; bytes are never held back once emitted.
// Reset empties the queue and the classify register; no strobe follows reset
// until an item is accepted.
`default_nettype none
module network_group_classifier_unit #(
  parameter int unsigned QueueDepth = ngc_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire ngc_pkg::in_item_t item_i,
  output logic                   valid_o,
  output ngc_pkg::out_item_t     result_o
);

  ngc_pkg::q_status_t q_st;
  ngc_pkg::group_t    push_grp, head_grp;
  logic               q_push, q_pop;

  ngc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .status_i (q_st),
    .push_o   (q_push),
    .group_o  (push_grp)
  );

  ngc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (push_grp),
    .pop_i    (q_pop),
    .head_o   (head_grp),
    .status_o (q_st)
  );

  ngc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_grp),
    .status_i (q_st),
    .pop_o    (q_pop),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // the byte after a final byte opens a new group, so it is a class code
  a_class_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.last |=> !valid_o || (result_o.group_byte <= ngc_pkg::ClsInternal))
    else $error("group did not open with a class code");

  a_busy_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> q_st.full)
    else $error("busy while queue has room");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_st.empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_st.full)
    else $error("push into full queue");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the network group classifier: directed table plus random addresses.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned ItemsPerPhase = 76;
  localparam int unsigned NumPhases = 4;

  localparam logic [47:0] OnionNet     = 48'hFD87_D87E_EB43;
  localparam logic [47:0] InternalNet  = 48'hFD6B_88C0_8724;
  localparam logic [95:0] Nat64Net     = 96'h0064_FF9B_0000_0000_0000_0000;
  localparam logic [95:0] SiitNet      = 96'h0000_0000_0000_0000_FFFF_0000;
  localparam logic [63:0] LinkLocalNet = 64'hFE80_0000_0000_0000;
  localparam logic [31:0] TeredoNet    = 32'h2001_0000;
  localparam logic [31:0] ProviderNet  = 32'h2001_0470;

  typedef struct {
    ngc_pkg::in_item_t  item;
    int unsigned        n_typed;
    logic [0:4][7:0]    typed;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  ngc_pkg::in_item_t  item_i = '0;
  logic               busy_o;
  logic               valid_o;
  ngc_pkg::out_item_t result_o;

  ngc_pkg::out_item_t group_q[$];
  stim_row_t          directed_rows[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned stall_cycles = 0;

  network_group_classifier_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  // Works out the group bytes of one address and queues them.
  function automatic void predict_group(ngc_pkg::in_item_t it);
    logic [0:15][7:0] ab;
    logic [7:0] grp[$];
    logic [7:0] p, q, r;
    logic v4, onion, intern, v6, loopbk, lcl;
    logic priv, bench, v4link, cgnat, doc4, p2001, v6link, ula, orchid, orchid2;
    logic sixto4, nat64, teredo, siit, routable;
    ngc_pkg::out_item_t o;
    v4 = it.is_v4;
    ab = v4 ? {80'h0, 16'hFFFF, it.addr_low[31:0]} : {it.addr_high, it.addr_low};
    onion  = !v4 && ab[0:5] == OnionNet;
    intern = !v4 && !onion && ab[0:5] == InternalNet;
    v6     = !v4 && !onion && !intern;
    if (v4) loopbk = ab[12] == 8'd127;
    else loopbk = ab[0:14] == '0 && ab[15] == 8'd1;
    lcl = loopbk || (v4 && ab[12] == 8'd0);
    p = ab[12];
    q = ab[13];
    r = ab[14];
    priv   = v4 && (p == 8'd10 || (p == 8'd192 && q == 8'd168) ||
                    (p == 8'd172 && q >= 8'd16 && q <= 8'd31));
    bench  = v4 && p == 8'd198 && (q == 8'd18 || q == 8'd19);
    v4link = v4 && p == 8'd169 && q == 8'd254;
    cgnat  = v4 && p == 8'd100 && q >= 8'd64 && q <= 8'd127;
    doc4   = v4 && ((p == 8'd192 && q == 8'd0 && r == 8'd2) ||
                    (p == 8'd198 && q == 8'd51 && r == 8'd100) ||
                    (p == 8'd203 && q == 8'd0 && r == 8'd113));
    p2001   = v6 && ab[0:1] == 16'h2001;
    v6link  = v6 && ab[0:7] == LinkLocalNet;
    ula     = v6 && ab[0][7:1] == 7'b1111_110;
    orchid  = p2001 && ab[2] == 8'h00 && ab[3][7:4] == 4'h1;
    orchid2 = p2001 && ab[2] == 8'h00 && ab[3][7:4] == 4'h2;
    sixto4  = v6 && ab[0:1] == 16'h2002;
    nat64   = v6 && ab[0:11] == Nat64Net;
    teredo  = p2001 && ab[2:3] == 16'h0000;
    siit    = v6 && ab[0:11] == SiitNet;
    routable = !(priv || bench || v4link || v6link || cgnat || doc4 ||
                 ula || orchid || orchid2 || lcl || intern);

    if (intern) begin
      grp.insert(grp.size(), ngc_pkg::ClsInternal);
      for (int i = 6; i < 16; i++) grp.insert(grp.size(), ab[i]);
    end else if (!routable) begin
      grp.insert(grp.size(), ngc_pkg::ClsUnroutable);
    end else if (v4 || siit || nat64 || sixto4 || teredo) begin
      grp.insert(grp.size(), ngc_pkg::ClsIpv4);
      if (v4 || siit || nat64) begin
        grp.insert(grp.size(), ab[12]);
        grp.insert(grp.size(), ab[13]);
      end else if (sixto4) begin
        grp.insert(grp.size(), ab[2]);
        grp.insert(grp.size(), ab[3]);
      end else begin
        // Teredo carries the client address inverted
        grp.insert(grp.size(), ~ab[12]);
        grp.insert(grp.size(), ~ab[13]);
      end
    end else if (onion) begin
      grp.insert(grp.size(), ngc_pkg::ClsOnion);
      grp.insert(grp.size(), ab[6] | 8'h0F);
    end else begin
      grp.insert(grp.size(), ngc_pkg::ClsIpv6);
      for (int i = 0; i < 4; i++) grp.insert(grp.size(), ab[i]);
      if (ab[0:3] == ProviderNet) grp.insert(grp.size(), ab[4] | 8'h0F);
    end

    foreach (grp[i]) begin
      o.group_byte = grp[i];
      o.last = (i == grp.size() - 1);
      group_q.insert(group_q.size(), o);
    end
  endfunction

  function automatic void add_row(logic [63:0] hi, logic [63:0] lo, logic v4,
                                  int unsigned n, logic [0:4][7:0] b);
    stim_row_t row;
    row.item.addr_high = hi;
    row.item.addr_low = lo;
    row.item.is_v4 = v4;
    row.n_typed = n;
    row.typed = b;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Random address, mostly built on one of the special prefixes.
  function automatic ngc_pkg::in_item_t gen_address();
    ngc_pkg::in_item_t it;
    logic [127:0] v;
    logic [31:0] a4, net, mask;
    int unsigned len, k;
    v = {$urandom, $urandom, $urandom, $urandom};
    a4 = $urandom;
    it.is_v4 = 1'b0;
    case ($urandom_range(0, 15))
      0: it.is_v4 = 1'b1;
      1: begin
        case ($urandom_range(0, 10))
          0: begin net = 32'h0A00_0000; len = 8; end
          1: begin net = 32'hAC10_0000; len = 12; end
          2: begin net = 32'hC0A8_0000; len = 16; end
          3: begin net = 32'hC612_0000; len = 15; end
          4: begin net = 32'hA9FE_0000; len = 16; end
          5: begin net = 32'h6440_0000; len = 10; end
          6: begin net = 32'hC000_0200; len = 24; end
          7: begin net = 32'hC633_6400; len = 24; end
          8: begin net = 32'hCB00_7100; len = 24; end
          9: begin net = 32'h0000_0000; len = 8; end
          default: begin net = 32'h7F00_0000; len = 8; end
        endcase
        mask = 32'hFFFF_FFFF << (32 - len);
        v[31:0] = (a4 & ~mask) | net;
        it.is_v4 = 1'b1;
      end
      2: ;
      3: v[127 -: 48] = OnionNet;
      4: v[127 -: 48] = InternalNet;
      5: v[127 -: 64] = LinkLocalNet;
      6: v[127 -: 7] = 7'b1111_110;
      7: begin
        v[127 -: 24] = 24'h2001_00;
        v[103:100] = 4'($urandom_range(1, 2));
      end
      8: v[127 -: 32] = TeredoNet;
      9: v[127 -: 16] = 16'h2002;
      10: v[127 -: 96] = Nat64Net;
      11: v[127 -: 96] = SiitNet;
      12: v[127 -: 32] = ProviderNet;
      13: begin
        // loopback, sometimes one bit off
        v = 128'h1;
        if ($urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, 127);
          v[k] = ~v[k];
        end
      end
      14: begin
        case ($urandom_range(0, 3))
          0: v[127 -: 48] = OnionNet;
          1: v[127 -: 48] = InternalNet;
          2: v[127 -: 96] = Nat64Net;
          default: v[127 -: 96] = SiitNet;
        endcase
        k = 127 - $urandom_range(0, 95);
        v[k] = ~v[k];
      end
      default: v = {80'h0, 16'hFFFF, a4};  // mapped form sent as IPv6
    endcase
    it.addr_high = v[127:64];
    it.addr_low = v[63:0];
    return it;
  endfunction

  // Drives one item and waits for it to be taken; queues what it should produce.
  task automatic send_item(ngc_pkg::in_item_t it, int unsigned n_typed,
                           logic [0:4][7:0] typed, int unsigned idle_pct);
    ngc_pkg::out_item_t o;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (n_typed == 0) begin
      predict_group(it);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        o.group_byte = typed[i];
        o.last = (i == n_typed - 1);
        group_q.insert(group_q.size(), o);
      end
    end
  endtask

  task automatic drain_groups();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (group_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    ngc_pkg::out_item_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (valid_o) begin
        if (group_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %0h last %0b",
                                    result_o.group_byte, result_o.last));
        end else begin
          want = group_q.pop_front();
          if (result_o.group_byte !== want.group_byte)
            report_mismatch($sformatf("group_byte %0h, expected %0h",
                                      result_o.group_byte, want.group_byte));
          if (result_o.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      result_o.last, want.last));
        end
        n_results++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no progress for %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned idle_pct;
    add_row(64'h0, 64'h0000_0000_0000_0000, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_7F00_0001, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_0AC8_0304, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_AC1F_FFFF, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_AC20_0001, 1'b1, 0, '0);
    add_row(64'h0, 64'h0000_0000_C0A8_0001, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_C613_0101, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_A9FE_0909, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_647F_FFFF, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_C000_02FF, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_C633_6401, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h0, 64'h0000_0000_CB00_71C8, 1'b1, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    // ignored upper bits all set
    add_row('1, '1, 1'b1, 3, {ngc_pkg::ClsIpv4, 16'hFFFF, 16'h0});
    add_row(64'h0, 64'h0, 1'b0, 5, {ngc_pkg::ClsIpv6, 32'h0});
    add_row('1, '1, 1'b0, 5, {ngc_pkg::ClsIpv6, 32'hFFFF_FFFF});
    add_row(64'h0, 64'h1, 1'b0, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'hFD87_D87E_EB43_5A00, 64'h1357_9BDF_2468_ACE0, 1'b0, 0, '0);
    add_row(64'hFD6B_88C0_8724_A5C3, 64'h0123_4567_89AB_CDEF, 1'b0, 0, '0);
    add_row(64'hFE80_0000_0000_0000, 64'h0000_0000_0000_1234, 1'b0, 1,
            {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'hFDFF_0000_0000_0001, 64'h0, 1'b0, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h2001_001F_0000_0000, 64'h0, 1'b0, 1, {ngc_pkg::ClsUnroutable, 32'h0});
    add_row(64'h2001_0000_4136_E378, 64'h8000_63BF_3FFF_FDD2, 1'b0, 0, '0);
    add_row(64'h2002_C000_0204_0000, 64'h0, 1'b0, 0, '0);
    add_row(64'h0064_FF9B_0000_0000, 64'h0000_0000_C633_6401, 1'b0, 0, '0);
    add_row(64'h0, 64'hFFFF_0000_0808_0404, 1'b0, 0, '0);
    add_row(64'h0, 64'h0000_FFFF_0102_0304, 1'b0, 0, '0);
    add_row(64'h2001_0470_ABCD_0000, 64'h0, 1'b0, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].n_typed, directed_rows[i].typed, 0);
    drain_groups();

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_pct = (ph == 1) ? 73 : (ph == 3) ? 29 : 0;
      for (int n = 0; n < ItemsPerPhase; n++)
        send_item(gen_address(), 0, '0, idle_pct);
      // hold off until everything queued has come out
      drain_groups();
    end

    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
